// ===== hdl/cal_pkg.sv =====
// Request and status codes and field widths for the cursor array list.
package cal_pkg;

	localparam int unsigned REQ_W   = 3;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned STAT_W  = 2;

	typedef logic [REQ_W-1:0]   req_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [STAT_W-1:0]  stat_t;

	localparam req_t REQ_INSERT = 3'd0;
	localparam req_t REQ_REMOVE = 3'd1;
	localparam req_t REQ_NEXT   = 3'd2;
	localparam req_t REQ_PREV   = 3'd3;
	localparam req_t REQ_COUNT  = 3'd4;

	localparam stat_t ST_DONE    = 2'd0;
	localparam stat_t ST_FULL    = 2'd1;
	localparam stat_t ST_NOTHING = 2'd2;

	localparam count_t COUNT_MAX = '1;

endpackage

// ===== hdl/cursor_array_list_unit.sv =====
// Cursor array list: ordered word store in one memory, walked one entry a cycle.
// Next, prev, unused codes and a rejected insert or remove skip the walk and go to the result;
// insert, remove and count walk n reads (n = length - cursor, length - cursor - 1, length)
// before the result. One request in flight: a new request is accepted only once the last
// result has been loaded into the output register.
// arst_n clears length, cursor, state and output valid; the entry memory is not cleared.
module cursor_array_list_unit
	import cal_pkg::*;
#(
	parameter int unsigned CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // match_count[7:0], status[9:8], zero pad[15:10]
);

	// address and length widths; length must also hold CAPACITY itself
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t          state_q;
	req_t            op_q;
	word_t           key_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   cur_q;
	logic [LW-1:0]   rem_q;      // reads still to issue
	logic [AW-1:0]   ptr_q;      // next read address
	count_t          hits_q;
	stat_t           st_q;
	logic            m_tvalid_q;
	logic [15:0]     m_tdata_q;

	// entry memory, one write and one registered read a cycle
	word_t           mem [CAPACITY];
	word_t           rdata_s1;
	logic [AW-1:0]   rd_addr_s1;
	logic            rd_vld_s1;

	logic            accept;
	logic            rd_issue;
	logic            finish;
	logic            out_free;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	word_t           mem_wdata;
	logic            is_ins;
	logic            is_rem;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign is_ins   = (op_q == REQ_INSERT);
	assign is_rem   = (op_q == REQ_REMOVE);
	assign rd_issue = (state_q == S_RUN) && (rem_q != '0);
	// walk done: nothing left to read and the last read data consumed
	assign finish   = (state_q == S_RUN) && (rem_q == '0) && !rd_vld_s1;
	assign out_free = !m_tvalid_q || m_tready;

	// insert moves entry r to r+1 walking down; remove moves r to r-1 walking up.
	// The read in the same cycle is always a different entry, so no forwarding.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = rdata_s1;
		if (state_q == S_RUN) begin
			if (rd_vld_s1 && (is_ins || is_rem)) begin
				mem_we    = 1'b1;
				mem_waddr = is_ins ? (rd_addr_s1 + AW'(1)) : (rd_addr_s1 - AW'(1));
			end else if (finish && is_ins) begin
				// new word lands at the cursor once the shift is over
				mem_we    = 1'b1;
				mem_wdata = key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rdata_s1 <= mem[ptr_q];
		end
		rd_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cur_q   <= '0;
			rem_q   <= '0;
			op_q    <= REQ_NEXT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= s_tuser;
						state_q <= S_RESP;
						case (s_tuser)
							REQ_INSERT: begin
								if (len_q != CAP_L) begin
									rem_q   <= len_q - cur_q;
									state_q <= S_RUN;
								end
							end
							REQ_REMOVE: begin
								if (cur_q < len_q) begin
									rem_q   <= len_q - cur_q - LW'(1);
									state_q <= S_RUN;
								end
							end
							REQ_NEXT: begin
								if (cur_q < len_q) begin
									cur_q <= cur_q + LW'(1);
								end
							end
							REQ_PREV: begin
								if (cur_q != '0) begin
									cur_q <= cur_q - LW'(1);
								end
							end
							REQ_COUNT: begin
								rem_q   <= len_q;
								state_q <= S_RUN;
							end
							default: ;
						endcase
					end
				end
				S_RUN: begin
					if (rd_issue) begin
						rem_q <= rem_q - LW'(1);
					end
					if (finish) begin
						if (is_ins) begin
							len_q <= len_q + LW'(1);
						end else if (is_rem) begin
							len_q <= len_q - LW'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers: key, read pointer, hit count, status
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= s_tdata;
			hits_q <= '0;
			st_q   <= ST_DONE;
			case (s_tuser)
				REQ_INSERT: begin
					ptr_q <= AW'(len_q - LW'(1));
					if (len_q == CAP_L) begin
						st_q <= ST_FULL;
					end
				end
				REQ_REMOVE: begin
					ptr_q <= AW'(cur_q + LW'(1));
					if (cur_q >= len_q) begin
						st_q <= ST_NOTHING;
					end
				end
				default: ptr_q <= '0;
			endcase
		end else begin
			if (rd_issue) begin
				ptr_q <= is_ins ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
			end
			if ((state_q == S_RUN) && rd_vld_s1 && (op_q == REQ_COUNT) &&
			    (rdata_s1 == key_q) && (hits_q != COUNT_MAX)) begin
				hits_q <= hits_q + COUNT_W'(1);
			end
		end
	end

	// output register: the result waits here until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_RESP) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			m_tdata_q <= {6'b0, st_q, hits_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/cal_checker.sv =====
// Port-level checker for the cursor array list, bound to the top level.
module cal_checker
	import cal_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// status code 3 is never produced
	a_stat_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:8] != 2'd3))
		else $error("illegal status code");

	// a nonzero count only comes with status done
	a_count_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[7:0] != 8'd0)) |-> (m_tdata[9:8] == ST_DONE))
		else $error("match count with failure status");

	// one request in flight: no accept on the cycle after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("back-to-back accept");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind cursor_array_list_unit cal_checker u_cal_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
